/* src/rpv_pkg.sv */
package rpv_pkg;

   localparam int unsigned MAX_LIMIT   = 4096;
   localparam int unsigned LIMIT_W     = 13;
   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned REASON_W    = 4;
   localparam int unsigned RSP_DATA_W  = 24;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(256);
   localparam logic [LIMIT_W-1:0] LIMIT_MAX   = LIMIT_W'(MAX_LIMIT);

   localparam logic [BYTE_W-1:0] CHAR_SLASH = 8'h2F;
   localparam logic [BYTE_W-1:0] CHAR_DASH  = 8'h2D;
   localparam logic [BYTE_W-1:0] CHAR_DOT   = 8'h2E;
   localparam logic [BYTE_W-1:0] CHAR_UNDER = 8'h5F;
   localparam logic [BYTE_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [BYTE_W-1:0] CHAR_LOW_G = 8'h67;
   localparam logic [BYTE_W-1:0] CHAR_LOW_I = 8'h69;
   localparam logic [BYTE_W-1:0] CHAR_LOW_T = 8'h74;

   localparam logic [2:0] GIT_LAST_STAGE = 3'd5;

   typedef enum logic [REASON_W-1:0] {
      REASON_OK         = 4'd0,
      REASON_EMPTY      = 4'd1,
      REASON_TOO_LONG   = 4'd2,
      REASON_BAD_FIRST  = 4'd3,
      REASON_GIT_DIR    = 4'd4,
      REASON_TRAIL_SL   = 4'd5,
      REASON_EMPTY_SEG  = 4'd6,
      REASON_DOT_SEG    = 4'd7,
      REASON_BAD_BYTE   = 4'd8
   } reason_type;

   typedef enum logic [1:0] {
      SEG_FAULT_NONE  = 2'd0,
      SEG_FAULT_EMPTY = 2'd1,
      SEG_FAULT_DOT   = 2'd2
   } seg_fault_type;

   typedef enum logic [1:0] {
      SEG_LEN_EMPTY = 2'd0,
      SEG_LEN_DOT   = 2'd1,
      SEG_LEN_DDOT  = 2'd2,
      SEG_LEN_OTHER = 2'd3
   } seg_len_type;

   function automatic logic [BYTE_W-1:0] git_char(input logic [2:0] stage);
      logic [BYTE_W-1:0] c;
      unique case (stage)
         3'd0:    c = CHAR_SLASH;
         3'd1:    c = CHAR_DOT;
         3'd2:    c = CHAR_LOW_G;
         3'd3:    c = CHAR_LOW_I;
         3'd4:    c = CHAR_LOW_T;
         default: c = CHAR_SLASH;
      endcase
      return c;
   endfunction

   function automatic logic byte_allowed(input logic [BYTE_W-1:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h30 && c <= 8'h39) || c == CHAR_DOT || c == CHAR_UNDER ||
             c == CHAR_SLASH || c == CHAR_PLUS || c == CHAR_DASH;
   endfunction

   function automatic seg_fault_type close_segment(input seg_fault_type fault,
                                                   input seg_len_type   len);
      seg_fault_type f;
      f = fault;
      if (fault == SEG_FAULT_NONE) begin
         if (len == SEG_LEN_EMPTY) begin
            f = SEG_FAULT_EMPTY;
         end else if (len == SEG_LEN_DOT || len == SEG_LEN_DDOT) begin
            f = SEG_FAULT_DOT;
         end
      end
      return f;
   endfunction

endpackage

/* src/relative_path_validator.sv */
// Relative path validator.
// A path enters one byte per transaction on the req_ channel: tdata carries the
// byte, tuser marks whether the byte is present (a transaction with tuser low is
// a bare end mark), and tlast closes the path. For each transaction with tlast
// high, one verdict transaction leaves on the rsp_ channel with the accept flag,
// the reject reason and the byte count, which saturates at the length limit.
// The limit is written through csr_we and csr_wdata, by the user only while the
// block is idle (unenforced); zero acts as one, values above 4096 act as 4096.
// The verdict is registered at the edge that accepts the closing transaction.
// Throughput is one transaction per cycle while no verdict is stalled, set by the
// single stage of running path flags that every byte updates.
// A new transaction is taken whenever the result register is empty or is being
// drained in the same cycle, so a stalled receiver holds req_tready low only
// while a verdict is waiting.
// Reset clears the running path flags and the output valid and sets the limit
// to 256.
module relative_path_validator (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // Fields: path_byte [7:0].
   input  logic [rpv_pkg::BYTE_W-1:0]         req_tdata,
   // Fields: byte_present [0].
   input  logic                               req_tuser,
   input  logic                               req_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // Fields: path_ok [0], reject_reason [4:1], path_length [17:5], zero [23:18].
   output logic [rpv_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                               csr_we,
   input  logic [rpv_pkg::LIMIT_W-1:0]        csr_wdata
);

   logic [rpv_pkg::LIMIT_W-1:0] limit_ff;
   logic [rpv_pkg::LIMIT_W-1:0] count_ff,       count_in;
   logic                        first_fault_ff, first_fault_in;
   logic [2:0]                  git_stage_ff,   git_stage_in;
   logic                        git_seen_ff,    git_seen_in;
   rpv_pkg::seg_len_type        seg_len_ff,     seg_len_in;
   rpv_pkg::seg_fault_type      seg_fault_ff,   seg_fault_in;
   logic                        bad_byte_ff,    bad_byte_in;
   logic                        prev_slash_ff,  prev_slash_in;

   logic                        rsp_valid_ff;
   logic [rpv_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [rpv_pkg::LIMIT_W-1:0] limit_eff;
   logic [rpv_pkg::LIMIT_W-1:0] count_clamped;
   logic                        accept;
   logic                        is_slash;
   rpv_pkg::seg_fault_type      final_fault;
   rpv_pkg::reason_type         reason;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign is_slash   = (req_tdata == rpv_pkg::CHAR_SLASH);

   always_comb begin
      if (limit_ff == '0) begin
         limit_eff = rpv_pkg::LIMIT_W'(1);
      end else if (limit_ff > rpv_pkg::LIMIT_MAX) begin
         limit_eff = rpv_pkg::LIMIT_MAX;
      end else begin
         limit_eff = limit_ff;
      end
      count_clamped = (count_ff > limit_eff) ? limit_eff : count_ff;
   end

   always_comb begin
      count_in       = count_clamped;
      first_fault_in = first_fault_ff;
      git_stage_in   = git_stage_ff;
      git_seen_in    = git_seen_ff;
      seg_len_in     = seg_len_ff;
      seg_fault_in   = seg_fault_ff;
      bad_byte_in    = bad_byte_ff;
      prev_slash_in  = prev_slash_ff;

      if (req_tuser) begin
         if (count_clamped == '0 && (is_slash || req_tdata == rpv_pkg::CHAR_DASH ||
                                     req_tdata == rpv_pkg::CHAR_DOT)) begin
            first_fault_in = 1'b1;
         end

         if (req_tdata == rpv_pkg::git_char(git_stage_ff)) begin
            if (git_stage_ff == rpv_pkg::GIT_LAST_STAGE) begin
               git_seen_in  = 1'b1;
               git_stage_in = 3'd1;
            end else begin
               git_stage_in = git_stage_ff + 3'd1;
            end
         end else begin
            git_stage_in = is_slash ? 3'd1 : 3'd0;
         end

         if (is_slash) begin
            seg_fault_in = rpv_pkg::close_segment(seg_fault_ff, seg_len_ff);
            seg_len_in   = rpv_pkg::SEG_LEN_EMPTY;
         end else if (req_tdata == rpv_pkg::CHAR_DOT) begin
            if (seg_len_ff != rpv_pkg::SEG_LEN_OTHER) begin
               seg_len_in = rpv_pkg::seg_len_type'(seg_len_ff + 2'd1);
            end
         end else begin
            seg_len_in = rpv_pkg::SEG_LEN_OTHER;
         end

         if (!rpv_pkg::byte_allowed(req_tdata)) begin
            bad_byte_in = 1'b1;
         end
         prev_slash_in = is_slash;

         if (count_clamped < limit_eff) begin
            count_in = count_clamped + rpv_pkg::LIMIT_W'(1);
         end
      end

      final_fault = rpv_pkg::close_segment(seg_fault_in, seg_len_in);

      priority if (count_in == '0) begin
         reason = rpv_pkg::REASON_EMPTY;
      end else if (count_in >= limit_eff) begin
         reason = rpv_pkg::REASON_TOO_LONG;
      end else if (first_fault_in) begin
         reason = rpv_pkg::REASON_BAD_FIRST;
      end else if (git_seen_in) begin
         reason = rpv_pkg::REASON_GIT_DIR;
      end else if (prev_slash_in) begin
         reason = rpv_pkg::REASON_TRAIL_SL;
      end else if (final_fault == rpv_pkg::SEG_FAULT_EMPTY) begin
         reason = rpv_pkg::REASON_EMPTY_SEG;
      end else if (final_fault == rpv_pkg::SEG_FAULT_DOT) begin
         reason = rpv_pkg::REASON_DOT_SEG;
      end else if (bad_byte_in) begin
         reason = rpv_pkg::REASON_BAD_BYTE;
      end else begin
         reason = rpv_pkg::REASON_OK;
      end

      rsp_data_in = {6'd0, count_in, reason, (reason == rpv_pkg::REASON_OK)};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= rpv_pkg::LIMIT_RESET;
      end else if (csr_we) begin
         limit_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= '0;
         first_fault_ff <= 1'b0;
         git_stage_ff   <= '0;
         git_seen_ff    <= 1'b0;
         seg_len_ff     <= rpv_pkg::SEG_LEN_EMPTY;
         seg_fault_ff   <= rpv_pkg::SEG_FAULT_NONE;
         bad_byte_ff    <= 1'b0;
         prev_slash_ff  <= 1'b0;
      end else if (accept) begin
         if (req_tlast) begin
            count_ff       <= '0;
            first_fault_ff <= 1'b0;
            git_stage_ff   <= '0;
            git_seen_ff    <= 1'b0;
            seg_len_ff     <= rpv_pkg::SEG_LEN_EMPTY;
            seg_fault_ff   <= rpv_pkg::SEG_FAULT_NONE;
            bad_byte_ff    <= 1'b0;
            prev_slash_ff  <= 1'b0;
         end else begin
            count_ff       <= count_in;
            first_fault_ff <= first_fault_in;
            git_stage_ff   <= git_stage_in;
            git_seen_ff    <= git_seen_in;
            seg_len_ff     <= seg_len_in;
            seg_fault_ff   <= seg_fault_in;
            bad_byte_ff    <= bad_byte_in;
            prev_slash_ff  <= prev_slash_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept && req_tlast) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_tlast) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

/* src/rpv_checker.sv */
module rpv_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic                               req_tlast,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [rpv_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   logic [rpv_pkg::REASON_W-1:0] rsp_reason;
   logic [rpv_pkg::LIMIT_W-1:0]  rsp_length;

   assign rsp_reason = rsp_tdata[4:1];
   assign rsp_length = rsp_tdata[17:5];

   // A closing transaction always produces a verdict in the next cycle.
   a_close_gives_verdict: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> rsp_tvalid)
      else $error("closing transaction produced no verdict");

   a_ok_matches_reason: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[0] == (rsp_reason == rpv_pkg::REASON_OK)))
      else $error("accept flag disagrees with reject reason");

   a_empty_matches_length: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_reason == rpv_pkg::REASON_EMPTY) == (rsp_length == '0)))
      else $error("empty reason disagrees with path length");

   a_length_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_length <= rpv_pkg::LIMIT_MAX))
      else $error("path length above the maximum limit");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled verdict changed");

endmodule

bind relative_path_validator rpv_checker u_rpv_checker (.*);
